@@ sv/ttpd_pkg.sv @@
package ttpd_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int RAD_W      = 2 * WORD_BITS;      // radicand of both square roots
    localparam int RT_W       = WORD_BITS;          // root bits, one per sqrt stage
    localparam int REM_W      = RT_W + 2;
    localparam int G_W        = WORD_BITS + 2;      // p - c, z side needs two extra bits
    localparam int DIST_W     = RT_W + 2;           // root after the x4 rescale
    localparam int DEN_W      = DIST_W;
    localparam int DREM_W     = DEN_W + 1;
    localparam int DNUM_W     = 2 * WORD_BITS;
    localparam int Q1_W       = WORD_BITS - 1;      // circle point quotient bits
    localparam int Q2_W       = FRAC_BITS + 1;      // unit vector quotient bits
    localparam int SAT_W      = WORD_BITS + 4;
    localparam int SCALE_SH   = 2;

    localparam logic [1:0] CFG_MAJOR  = 2'd0;
    localparam logic [1:0] CFG_MINOR  = 2'd1;
    localparam logic [1:0] CFG_BOTTOM = 2'd2;

    localparam logic [WORD_BITS-2:0] MINOR_RST =
        {{(WORD_BITS - 2 - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [Q2_W-1:0] UNIT_Q = {1'b1, {FRAC_BITS{1'b0}}};

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [WORD_BITS-2:0]        t_ureg;
    typedef logic signed [G_W-1:0]       t_diff;
    typedef logic signed [SAT_W-1:0]     t_wide;

    typedef struct packed {
        t_word px;
        t_word py;
        t_word pz;
    } t_pt;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
    } t_sqrt;

    typedef struct packed {
        logic [DNUM_W-1:0]    num;
        logic [DEN_W-1:0]     den;
        logic [DREM_W-1:0]    rem;
        logic [WORD_BITS-1:0] q;
    } t_div;

    typedef struct packed {
        t_pt  pt;
        logic le;
    } t_mid;

    typedef struct packed {
        t_pt               pt;
        logic              le;
        t_word             cx;
        t_word             cy;
        t_diff             gx;
        t_diff             gy;
        t_diff             gz;
        logic              sh;
        logic [DIST_W-1:0] dlen;
        logic              outside;
    } t_tail;

    // one result bit of a floor square root
    function automatic t_sqrt sqrt_step(t_sqrt s);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        t_sqrt            o;
        cur    = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
        trial  = {s.root, 2'b01};
        o.rad  = s.rad << 2;
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[RT_W-2:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[RT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // quotient has qbits bits; top part of n preloads the remainder
    function automatic t_div div_init(logic [DNUM_W-1:0] n, logic [DEN_W-1:0] den,
                                      int unsigned qbits);
        t_div o;
        o.rem = DREM_W'(n >> qbits);
        o.num = n << (DNUM_W - qbits);
        o.den = den;
        o.q   = '0;
        return o;
    endfunction

    // one restoring division step
    function automatic t_div div_step(t_div s);
        logic [DREM_W-1:0] cur;
        t_div              o;
        cur   = {s.rem[DREM_W-2:0], s.num[DNUM_W-1]};
        o     = s;
        o.num = s.num << 1;
        if (cur >= {1'b0, s.den}) begin
            o.rem = cur - {1'b0, s.den};
            o.q   = {s.q[WORD_BITS-2:0], 1'b1};
        end else begin
            o.rem = cur;
            o.q   = {s.q[WORD_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [WORD_BITS-1:0] mag_word(t_word v);
        logic [WORD_BITS-1:0] u;
        u = v;
        return v[WORD_BITS-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic [G_W-1:0] mag_diff(t_diff v);
        logic [G_W-1:0] u;
        u = v;
        return v[G_W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic t_wide with_sign(logic neg, logic [WORD_BITS-1:0] m);
        t_wide w;
        w = t_wide'({1'b0, m});
        return neg ? -w : w;
    endfunction

    function automatic t_word sat_word(t_wide v);
        logic fits;
        fits = (&v[SAT_W-1:WORD_BITS-1]) || !(|v[SAT_W-1:WORD_BITS-1]);
        if (fits) begin
            return v[WORD_BITS-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(WORD_BITS - 1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_BITS - 1){1'b1}}};
        end
    endfunction

endpackage

@@ sv/torus_tool_point_distance.sv @@
// Signed distance from a query point to a toroidal cutter, with gradient and
// nearest surface point, all signed Q16.16 with saturation.
// Config: i_cfg_we / i_cfg_idx / i_cfg_data write major radius R (index 0),
// minor radius r (index 1) and bottom height d (index 2); write only while
// the pipe is empty. Reset gives R = 0, r = 1.0, d = 0.
// Input beat (s_axis_*): one point. Output beat (m_axis_*): one result.
// Throughput: one beat per cycle unless the output stalls. The pipe is made of
// two 32-stage square roots (one bit per stage), the 31-stage circle-point
// divider and the 17-stage unit-vector dividers, plus multiply/add stages
// around them.
// The whole pipe advances on one enable: it moves whenever the output
// register is empty or being taken. With m_axis_tready low and a result
// waiting, every stage holds and s_axis_tready drops; nothing is dropped
// or replayed. Reset clears all stage valid bits and the output valid.
module torus_tool_point_distance (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [ttpd_pkg::WORD_BITS-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // point_x, point_y, point_z
    input  logic [3*ttpd_pkg::WORD_BITS-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // signed_distance, grad_x, grad_y, grad_z, near_x, near_y, near_z
    output logic [7*ttpd_pkg::WORD_BITS-1:0]   m_axis_tdata
);
    import ttpd_pkg::*;

    // ---------------- config registers ----------------
    t_ureg r_major;
    t_ureg r_minor;
    t_word r_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major  <= '0;
            r_minor  <= MINOR_RST;
            r_bottom <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAJOR:  r_major  <= i_cfg_data[WORD_BITS-2:0];
                CFG_MINOR:  r_minor  <= i_cfg_data[WORD_BITS-2:0];
                CFG_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tube center height m and top D
    t_diff             w_mid;
    t_wide             w_top;
    logic [DIST_W-1:0] w_minor_d;
    assign w_mid     = t_diff'(r_bottom) + t_diff'({1'b0, r_minor});
    assign w_top     = t_wide'(r_bottom) + t_wide'({1'b0, r_minor})
                     + t_wide'({1'b0, r_minor});
    assign w_minor_d = DIST_W'(r_minor);

    // ---------------- global pipe enable ----------------
    logic r_out_v;
    logic w_adv;
    assign w_adv         = !r_out_v || m_axis_tready;
    assign s_axis_tready = w_adv;

    // ---------------- A: |p.xy|^2 ----------------
    t_pt                  w_in_pt;
    logic [WORD_BITS-1:0] w_ax_in;
    logic [WORD_BITS-1:0] w_ay_in;
    assign w_in_pt.px = s_axis_tdata[0*WORD_BITS +: WORD_BITS];
    assign w_in_pt.py = s_axis_tdata[1*WORD_BITS +: WORD_BITS];
    assign w_in_pt.pz = s_axis_tdata[2*WORD_BITS +: WORD_BITS];
    assign w_ax_in    = mag_word(w_in_pt.px);
    assign w_ay_in    = mag_word(w_in_pt.py);

    logic             r_a0_v, r_a1_v;
    t_pt              r_a0_p, r_a1_p;
    logic [RAD_W-1:0] r_a0_sqx, r_a0_sqy, r_a1_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0_v <= 1'b0;
            r_a1_v <= 1'b0;
        end else if (w_adv) begin
            r_a0_v <= s_axis_tvalid;
            r_a1_v <= r_a0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a0_p   <= w_in_pt;
            r_a0_sqx <= RAD_W'(w_ax_in) * RAD_W'(w_ax_in);
            r_a0_sqy <= RAD_W'(w_ay_in) * RAD_W'(w_ay_in);
            r_a1_p   <= r_a0_p;
            r_a1_sum <= r_a0_sqx + r_a0_sqy;
        end
    end

    // ---------------- S1: rho = isqrt, one bit per stage ----------------
    t_sqrt r_s1 [RT_W];
    t_sqrt w_s1_in [RT_W];
    logic  r_s1_v [RT_W];
    logic  w_s1_vin [RT_W];
    t_pt   r_s1_p [RT_W];
    t_pt   w_s1_pin [RT_W];

    assign w_s1_in[0]  = '{rad: r_a1_sum, rem: '0, root: '0};
    assign w_s1_vin[0] = r_a1_v;
    assign w_s1_pin[0] = r_a1_p;

    for (genvar k = 1; k < RT_W; k++) begin : g_s1_link
        assign w_s1_in[k]  = r_s1[k-1];
        assign w_s1_vin[k] = r_s1_v[k-1];
        assign w_s1_pin[k] = r_s1_p[k-1];
    end

    for (genvar k = 0; k < RT_W; k++) begin : g_s1
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s1_v[k] <= 1'b0;
            end else if (w_adv) begin
                r_s1_v[k] <= w_s1_vin[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s1[k]   <= sqrt_step(w_s1_in[k]);
                r_s1_p[k] <= w_s1_pin[k];
            end
        end
    end

    // ---------------- B0: |p.x|*R, |p.y|*R ----------------
    logic [RT_W-1:0]      w_rho;
    logic [WORD_BITS-1:0] w_ax_b, w_ay_b;
    assign w_rho  = r_s1[RT_W-1].root;
    assign w_ax_b = mag_word(r_s1_p[RT_W-1].px);
    assign w_ay_b = mag_word(r_s1_p[RT_W-1].py);

    logic              r_b0_v;
    t_mid              r_b0_m;
    logic [RT_W-1:0]   r_b0_rho;
    logic [DNUM_W-1:0] r_b0_nx, r_b0_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
        end else if (w_adv) begin
            r_b0_v <= r_s1_v[RT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b0_m.pt <= r_s1_p[RT_W-1];
            r_b0_m.le <= (w_rho <= {1'b0, r_major});
            r_b0_rho  <= w_rho;
            r_b0_nx   <= DNUM_W'(w_ax_b) * DNUM_W'(r_major);
            r_b0_ny   <= DNUM_W'(w_ay_b) * DNUM_W'(r_major);
        end
    end

    // ---------------- D1: circle point quotients, |p|*R / rho ----------------
    t_div r_d1x [Q1_W];
    t_div r_d1y [Q1_W];
    t_div w_d1x_in [Q1_W];
    t_div w_d1y_in [Q1_W];
    logic r_d1_v [Q1_W];
    logic w_d1_vin [Q1_W];
    t_mid r_d1_m [Q1_W];
    t_mid w_d1_min [Q1_W];

    assign w_d1x_in[0] = div_init(r_b0_nx, DEN_W'(r_b0_rho), Q1_W);
    assign w_d1y_in[0] = div_init(r_b0_ny, DEN_W'(r_b0_rho), Q1_W);
    assign w_d1_vin[0] = r_b0_v;
    assign w_d1_min[0] = r_b0_m;

    for (genvar k = 1; k < Q1_W; k++) begin : g_d1_link
        assign w_d1x_in[k] = r_d1x[k-1];
        assign w_d1y_in[k] = r_d1y[k-1];
        assign w_d1_vin[k] = r_d1_v[k-1];
        assign w_d1_min[k] = r_d1_m[k-1];
    end

    for (genvar k = 0; k < Q1_W; k++) begin : g_d1
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_v[k] <= 1'b0;
            end else if (w_adv) begin
                r_d1_v[k] <= w_d1_vin[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d1x[k]  <= div_step(w_d1x_in[k]);
                r_d1y[k]  <= div_step(w_d1y_in[k]);
                r_d1_m[k] <= w_d1_min[k];
            end
        end
    end

    // ---------------- C0: circle point c, difference p - c ----------------
    t_mid                 w_c_m;
    logic [Q1_W-1:0]      w_qx, w_qy;
    t_word                w_cx, w_cy;
    t_diff                w_gx, w_gy, w_gz;
    logic [G_W-1:0]       w_mx, w_my, w_mz;
    logic                 w_sh;
    logic [WORD_BITS-1:0] w_smx, w_smy, w_smz;

    assign w_c_m = r_d1_m[Q1_W-1];
    assign w_qx  = r_d1x[Q1_W-1].q[Q1_W-1:0];
    assign w_qy  = r_d1y[Q1_W-1].q[Q1_W-1:0];

    always_comb begin
        if (w_c_m.le) begin
            w_cx = w_c_m.pt.px;
            w_cy = w_c_m.pt.py;
        end else begin
            w_cx = w_c_m.pt.px[WORD_BITS-1] ? -t_word'({1'b0, w_qx}) : t_word'({1'b0, w_qx});
            w_cy = w_c_m.pt.py[WORD_BITS-1] ? -t_word'({1'b0, w_qy}) : t_word'({1'b0, w_qy});
        end
    end

    assign w_gx = t_diff'(w_c_m.pt.px) - t_diff'(w_cx);
    assign w_gy = t_diff'(w_c_m.pt.py) - t_diff'(w_cy);
    assign w_gz = t_diff'(w_c_m.pt.pz) - w_mid;
    assign w_mx = mag_diff(w_gx);
    assign w_my = mag_diff(w_gy);
    assign w_mz = mag_diff(w_gz);
    // any magnitude at 2^31 or above: square a quarter and scale the root back
    assign w_sh = (|w_mx[G_W-1:WORD_BITS-1]) || (|w_my[G_W-1:WORD_BITS-1])
               || (|w_mz[G_W-1:WORD_BITS-1]);
    assign w_smx = w_sh ? WORD_BITS'(w_mx >> SCALE_SH) : w_mx[WORD_BITS-1:0];
    assign w_smy = w_sh ? WORD_BITS'(w_my >> SCALE_SH) : w_my[WORD_BITS-1:0];
    assign w_smz = w_sh ? WORD_BITS'(w_mz >> SCALE_SH) : w_mz[WORD_BITS-1:0];

    logic                 r_c0_v, r_c1_v, r_c2_v;
    t_tail                r_c0_t, r_c1_t, r_c2_t;
    logic [WORD_BITS-1:0] r_c0_smx, r_c0_smy, r_c0_smz;
    logic [RAD_W-1:0]     r_c1_sqx, r_c1_sqy, r_c1_sqz;
    logic [RAD_W-1:0]     r_c2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else if (w_adv) begin
            r_c0_v <= r_d1_v[Q1_W-1];
            r_c1_v <= r_c0_v;
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c0_t.pt      <= w_c_m.pt;
            r_c0_t.le      <= w_c_m.le;
            r_c0_t.cx      <= w_cx;
            r_c0_t.cy      <= w_cy;
            r_c0_t.gx      <= w_gx;
            r_c0_t.gy      <= w_gy;
            r_c0_t.gz      <= w_gz;
            r_c0_t.sh      <= w_sh;
            r_c0_t.dlen    <= '0;
            r_c0_t.outside <= 1'b0;
            r_c0_smx       <= w_smx;
            r_c0_smy       <= w_smy;
            r_c0_smz       <= w_smz;
            r_c1_t         <= r_c0_t;
            r_c1_sqx       <= RAD_W'(r_c0_smx) * RAD_W'(r_c0_smx);
            r_c1_sqy       <= RAD_W'(r_c0_smy) * RAD_W'(r_c0_smy);
            r_c1_sqz       <= RAD_W'(r_c0_smz) * RAD_W'(r_c0_smz);
            r_c2_t         <= r_c1_t;
            r_c2_sum       <= r_c1_sqx + r_c1_sqy + r_c1_sqz;
        end
    end

    // ---------------- S2: |p - c| ----------------
    t_sqrt r_s2 [RT_W];
    t_sqrt w_s2_in [RT_W];
    logic  r_s2_v [RT_W];
    logic  w_s2_vin [RT_W];
    t_tail r_s2_t [RT_W];
    t_tail w_s2_tin [RT_W];

    assign w_s2_in[0]  = '{rad: r_c2_sum, rem: '0, root: '0};
    assign w_s2_vin[0] = r_c2_v;
    assign w_s2_tin[0] = r_c2_t;

    for (genvar k = 1; k < RT_W; k++) begin : g_s2_link
        assign w_s2_in[k]  = r_s2[k-1];
        assign w_s2_vin[k] = r_s2_v[k-1];
        assign w_s2_tin[k] = r_s2_t[k-1];
    end

    for (genvar k = 0; k < RT_W; k++) begin : g_s2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s2_v[k] <= 1'b0;
            end else if (w_adv) begin
                r_s2_v[k] <= w_s2_vin[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s2[k]   <= sqrt_step(w_s2_in[k]);
                r_s2_t[k] <= w_s2_tin[k];
            end
        end
    end

    // ---------------- D0: distance and the outside test ----------------
    logic [RT_W-1:0]   w_root2;
    logic [DIST_W-1:0] w_dlen;
    t_tail             w_d0_t;
    assign w_root2 = r_s2[RT_W-1].root;
    assign w_dlen  = r_s2_t[RT_W-1].sh ? {w_root2, 2'b00} : DIST_W'(w_root2);

    always_comb begin
        w_d0_t         = r_s2_t[RT_W-1];
        w_d0_t.dlen    = w_dlen;
        w_d0_t.outside = (w_dlen > w_minor_d);
    end

    logic  r_d0_v;
    t_tail r_d0_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_v <= 1'b0;
        end else if (w_adv) begin
            r_d0_v <= r_s2_v[RT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d0_t <= w_d0_t;
        end
    end

    // ---------------- D2: unit vector, |g| * 2^FRAC / distance ----------------
    logic [DNUM_W-1:0] w_un [3];
    assign w_un[0] = DNUM_W'(mag_diff(r_d0_t.gx)) << FRAC_BITS;
    assign w_un[1] = DNUM_W'(mag_diff(r_d0_t.gy)) << FRAC_BITS;
    assign w_un[2] = DNUM_W'(mag_diff(r_d0_t.gz)) << FRAC_BITS;

    t_div  r_d2 [3][Q2_W];
    t_div  w_d2_in [3][Q2_W];
    logic  r_d2_v [Q2_W];
    logic  w_d2_vin [Q2_W];
    t_tail r_d2_t [Q2_W];
    t_tail w_d2_tin [Q2_W];

    assign w_d2_vin[0] = r_d0_v;
    assign w_d2_tin[0] = r_d0_t;

    for (genvar k = 1; k < Q2_W; k++) begin : g_d2_link
        assign w_d2_vin[k] = r_d2_v[k-1];
        assign w_d2_tin[k] = r_d2_t[k-1];
    end

    for (genvar a = 0; a < 3; a++) begin : g_d2_axis
        assign w_d2_in[a][0] = div_init(w_un[a], r_d0_t.dlen, Q2_W);
        for (genvar k = 1; k < Q2_W; k++) begin : g_link
            assign w_d2_in[a][k] = r_d2[a][k-1];
        end
        for (genvar k = 0; k < Q2_W; k++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_d2[a][k] <= div_step(w_d2_in[a][k]);
                end
            end
        end
    end

    for (genvar k = 0; k < Q2_W; k++) begin : g_d2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_v[k] <= 1'b0;
            end else if (w_adv) begin
                r_d2_v[k] <= w_d2_vin[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d2_t[k] <= w_d2_tin[k];
            end
        end
    end

    // ---------------- E0: r * unit, truncated at the binary point ----------------
    logic                 r_e0_v;
    t_tail                r_e0_t;
    logic [Q2_W-1:0]      r_e0_q [3];
    logic [WORD_BITS-1:0] r_e0_s [3];
    logic [DNUM_W-1:0]    w_rq [3];

    for (genvar a = 0; a < 3; a++) begin : g_e0
        assign w_rq[a] = DNUM_W'(r_minor) * DNUM_W'(r_d2[a][Q2_W-1].q[Q2_W-1:0]);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_e0_q[a] <= r_d2[a][Q2_W-1].q[Q2_W-1:0];
                r_e0_s[a] <= w_rq[a][FRAC_BITS +: WORD_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_v <= 1'b0;
        end else if (w_adv) begin
            r_e0_v <= r_d2_v[Q2_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e0_t <= r_d2_t[Q2_W-1];
        end
    end

    // ---------------- output stage ----------------
    t_word n_sd, n_gx, n_gy, n_gz, n_nx, n_ny, n_nz;

    always_comb begin
        n_sd = sat_word($signed({2'b00, r_e0_t.dlen}) - t_wide'({1'b0, r_minor}));
        if (r_e0_t.outside) begin
            n_gx = sat_word(with_sign(r_e0_t.gx[G_W-1], WORD_BITS'(r_e0_q[0])));
            n_gy = sat_word(with_sign(r_e0_t.gy[G_W-1], WORD_BITS'(r_e0_q[1])));
            n_gz = sat_word(with_sign(r_e0_t.gz[G_W-1], WORD_BITS'(r_e0_q[2])));
            if (r_e0_t.le) begin
                // inside the ring: snap to top, or to the bottom below d
                n_nx = r_e0_t.cx;
                n_ny = r_e0_t.cy;
                n_nz = (r_e0_t.pt.pz < r_bottom) ? r_bottom : sat_word(w_top);
            end else begin
                n_nx = sat_word(t_wide'(r_e0_t.cx)
                              + with_sign(r_e0_t.gx[G_W-1], r_e0_s[0]));
                n_ny = sat_word(t_wide'(r_e0_t.cy)
                              + with_sign(r_e0_t.gy[G_W-1], r_e0_s[1]));
                n_nz = sat_word(t_wide'(w_mid)
                              + with_sign(r_e0_t.gz[G_W-1], r_e0_s[2]));
            end
        end else begin
            // within the tube: raw difference, point is its own nearest point
            n_gx = sat_word(t_wide'(r_e0_t.gx));
            n_gy = sat_word(t_wide'(r_e0_t.gy));
            n_gz = sat_word(t_wide'(r_e0_t.gz));
            n_nx = r_e0_t.pt.px;
            n_ny = r_e0_t.pt.py;
            n_nz = r_e0_t.pt.pz;
        end
    end

    t_word r_sd, r_gx, r_gy, r_gz, r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_e0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd <= n_sd;
            r_gx <= n_gx;
            r_gy <= n_gy;
            r_gz <= n_gz;
            r_nx <= n_nx;
            r_ny <= n_ny;
            r_nz <= n_nz;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_nz, r_ny, r_nx, r_gz, r_gy, r_gx, r_sd};

`ifndef SYNTHESIS
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // the rescaled root never falls more than 3 below any component
    a_dist_covers_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d0_v |-> ((DIST_W + 1)'(mag_diff(r_d0_t.gx)) <= {1'b0, r_d0_t.dlen} + 3'd3)
                && ((DIST_W + 1)'(mag_diff(r_d0_t.gy)) <= {1'b0, r_d0_t.dlen} + 3'd3)
                && ((DIST_W + 1)'(mag_diff(r_d0_t.gz)) <= {1'b0, r_d0_t.dlen} + 3'd3))
        else $error("distance root below difference magnitude");

    // unit vector components stay within 1.0 when outside the tube
    a_unit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e0_v && r_e0_t.outside) |-> (r_e0_q[0] <= UNIT_Q) && (r_e0_q[1] <= UNIT_Q)
                                     && (r_e0_q[2] <= UNIT_Q))
        else $error("unit vector component above one");
`endif

endmodule

@@ bench/ttpd_checker.sv @@
module ttpd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [ttpd_pkg::WORD_BITS-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [3*ttpd_pkg::WORD_BITS-1:0]   i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [7*ttpd_pkg::WORD_BITS-1:0]   i_out_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ttpd_pkg::*;

    typedef logic [7*WORD_BITS-1:0] t_tool_result;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    // shadow registers
    longint unsigned major_r;
    longint unsigned minor_r;
    longint          bottom_z;

    t_tool_result expected_results[$];
    int           fail_count;
    int           result_count;

    string field_names[7] = '{"signed_distance", "grad_x", "grad_y", "grad_z",
                              "near_x", "near_y", "near_z"};

    assign o_fail_count = fail_count;

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bit_v;
        res   = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x   = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint apply_sign(bit neg, longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [WORD_BITS-1:0] clamp_word(longint v);
        if (v > WMAX) v = WMAX;
        if (v < WMIN) v = WMIN;
        return v[WORD_BITS-1:0];
    endfunction

    // |(a,b,c)|, pre-scaled by 4 when a component is too big to square
    function automatic longint unsigned length3(longint a, longint b, longint c);
        longint unsigned x, y, z;
        int              s;
        x = abs64(a);
        y = abs64(b);
        z = abs64(c);
        s = 0;
        if (x >= 64'd1 << 31 || y >= 64'd1 << 31 || z >= 64'd1 << 31) begin
            s = 2;
            x = x >> 2;
            y = y >> 2;
            z = z >> 2;
        end
        return root_floor(x * x + y * y + z * z) << s;
    endfunction

    function automatic t_tool_result predict_tool_distance(t_word qx, t_word qy, t_word qz);
        longint          px, py, pz, m, top, cx, cy, cz;
        longint          gx, gy, gz, nx, ny, nz;
        longint unsigned ax, ay, rho, dlen;
        px  = qx;
        py  = qy;
        pz  = qz;
        m   = bottom_z + longint'(minor_r);
        top = bottom_z + 2 * longint'(minor_r);
        ax  = abs64(px);
        ay  = abs64(py);
        rho = root_floor(ax * ax + ay * ay);
        cz  = m;
        if (rho <= major_r) begin
            cx = px;
            cy = py;
        end else begin
            cx = apply_sign(px < 0, (ax * major_r) / rho);
            cy = apply_sign(py < 0, (ay * major_r) / rho);
        end
        gx   = px - cx;
        gy   = py - cy;
        gz   = pz - cz;
        dlen = length3(gx, gy, gz);
        if (dlen > minor_r) begin
            // normalized gradient, then push the circle point out by r
            gx = apply_sign(gx < 0, (abs64(gx) << FRAC_BITS) / dlen);
            gy = apply_sign(gy < 0, (abs64(gy) << FRAC_BITS) / dlen);
            gz = apply_sign(gz < 0, (abs64(gz) << FRAC_BITS) / dlen);
            if (rho <= major_r) begin
                nx = cx;
                ny = cy;
                nz = (pz < bottom_z) ? bottom_z : top;
            end else begin
                nx = cx + apply_sign(gx < 0, (minor_r * abs64(gx)) >> FRAC_BITS);
                ny = cy + apply_sign(gy < 0, (minor_r * abs64(gy)) >> FRAC_BITS);
                nz = cz + apply_sign(gz < 0, (minor_r * abs64(gz)) >> FRAC_BITS);
            end
        end else begin
            nx = px;
            ny = py;
            nz = pz;
        end
        return {clamp_word(nz), clamp_word(ny), clamp_word(nx), clamp_word(gz),
                clamp_word(gy), clamp_word(gx),
                clamp_word(longint'(dlen) - longint'(minor_r))};
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    initial begin
        fail_count   = 0;
        result_count = 0;
        o_pending    = 0;
        major_r      = 0;
        minor_r      = 64'd1 << FRAC_BITS;
        bottom_z     = 0;
    end

    always @(posedge i_clk) begin
        t_tool_result got, want;
        if (!i_rst_n) begin
            major_r  = 0;
            minor_r  = 64'd1 << FRAC_BITS;
            bottom_z = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAJOR:  major_r  = i_cfg_data[WORD_BITS-2:0];
                    CFG_MINOR:  minor_r  = i_cfg_data[WORD_BITS-2:0];
                    CFG_BOTTOM: bottom_z = t_word'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_tool_distance(
                    i_in_data[WORD_BITS-1:0], i_in_data[2*WORD_BITS-1:WORD_BITS],
                    i_in_data[3*WORD_BITS-1:2*WORD_BITS]));
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected: %h", got));
                end else begin
                    want = expected_results.pop_front();
                    for (int f = 0; f < 7; f++) begin
                        if (got[f*WORD_BITS +: WORD_BITS] !== want[f*WORD_BITS +: WORD_BITS])
                            report_mismatch($sformatf("beat %0d %s got %h want %h",
                                result_count, field_names[f],
                                got[f*WORD_BITS +: WORD_BITS],
                                want[f*WORD_BITS +: WORD_BITS]));
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ bench/tb_torus_tool_point_distance.sv @@
module tb_torus_tool_point_distance;
    timeunit 1ns;
    timeprecision 1ps;
    import ttpd_pkg::*;

    localparam int PIPE_LAT  = 121;   // input beat to output valid
    localparam int NUM_RAND  = 1000;
    localparam int CALM_TAIL = 150;   // final beats sent with no idling

    localparam logic [WORD_BITS-1:0] W_MAX = 32'h7fff_ffff;
    localparam logic [WORD_BITS-1:0] W_MIN = 32'h8000_0000;
    localparam logic [WORD_BITS-1:0] ONE_Q = 32'h0001_0000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_idx = CFG_MAJOR;
    logic [WORD_BITS-1:0]   i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // point_x, point_y, point_z
    logic [3*WORD_BITS-1:0] s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // signed_distance, grad_x, grad_y, grad_z, near_x, near_y, near_z
    logic [7*WORD_BITS-1:0] m_axis_tdata;

    int  fail_count;
    int  pending;
    bit  calm;          // no idling on either side
    int  sent;
    int  rx_hold;
    longint cur_major, cur_minor, cur_bottom;

    always #6 i_clk = ~i_clk;

    torus_tool_point_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ttpd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stall bursts, none in the calm tail.
    initial rx_hold = 0;
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if (calm || $urandom_range(0, 4) != 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_hold = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_point(logic [WORD_BITS-1:0] x, logic [WORD_BITS-1:0] y,
                              logic [WORD_BITS-1:0] z);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
    endtask

    // Sender gap of random length now and then.
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    // Drain everything, then hold the channel quiet for a pipe's worth.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 8) @(negedge i_clk);
    endtask

    // Writes R, r, d back to back; only called with the pipe empty.
    task automatic set_tool(logic [WORD_BITS-1:0] maj, logic [WORD_BITS-1:0] mnr,
                            logic [WORD_BITS-1:0] bot);
        logic [WORD_BITS-1:0] vals[3];
        vals = '{maj, mnr, bot};
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            i_cfg_idx  <= 2'(k);
            i_cfg_data <= vals[k];
            @(negedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        cur_major  = maj[WORD_BITS-2:0];
        cur_minor  = mnr[WORD_BITS-2:0];
        cur_bottom = t_word'(bot);
    endtask

    // Coordinate biased toward the tool: full range, near the ring, or extremes.
    function automatic logic [WORD_BITS-1:0] pick_coord(bit is_z);
        longint span, base, v;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return '0;
                    3: return '1;
                    default: return ONE_Q;
                endcase
            end
            default: begin
                span = cur_major + 3 * cur_minor + 64'd65536;
                if (span > 64'sd2147483647) span = 64'sd2147483647;
                base = is_z ? cur_bottom + cur_minor : 0;
                v = base + longint'({$urandom, $urandom} % (2 * span + 1)) - span;
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                return v[WORD_BITS-1:0];
            end
        endcase
    endfunction

    task automatic random_points(int n, int calm_from);
        for (int k = 0; k < n; k++) begin
            if (k >= calm_from) calm = 1'b1;
            maybe_gap();
            send_point(pick_coord(0), pick_coord(0), pick_coord(1));
        end
    endtask

    task automatic extreme_points();
        send_point(W_MAX, W_MAX, W_MAX);
        send_point(W_MIN, W_MIN, W_MIN);
        send_point(W_MIN, W_MAX, '0);
        send_point('0, '0, W_MIN);
    endtask

    initial begin
        #20ms;
        $display("torus_tool_point_distance verification failed");
        $finish;
    end

    initial begin
        sent = 0;
        calm = 1'b0;
        cur_major = 0;
        cur_minor = 65536;
        cur_bottom = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset tool (R = 0, r = 1.0, d = 0): a few points first.
        send_point('0, '0, '0);
        send_point(ONE_Q, '0, ONE_Q);
        extreme_points();
        drain();

        // Directed: R = 4, r = 1, d = -2.
        set_tool(32'h0004_0000, 32'h8001_0000, 32'hfffe_0000);  // top bit of r ignored
        send_point('0, '0, 32'hffff_0000);            // on the axis, inside R
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0010_0000); // above, inside R
        send_point(32'h0001_0000, '0, 32'hfff0_0000); // below the bottom
        send_point(32'h0004_8000, '0, 32'hffff_0000); // inside the tube
        send_point(32'hfffa_0000, 32'h0003_0000, 32'hffff_0000); // just beyond the ring
        send_point(32'h0040_0000, 32'hffc0_0000, 32'h0020_0000); // far outside
        send_point(32'h0004_0000, '0, 32'hffff_0000); // on the centre circle
        extreme_points();
        drain();

        // Zero tube radius.
        set_tool(32'h0002_0000, '0, '0);
        send_point(32'h0002_0000, '0, '0);
        send_point(32'h0005_0000, 32'h0001_0000, 32'h0003_0000);
        random_points(120, NUM_RAND);
        drain();

        // Largest R and r, lowest and highest bottom.
        set_tool(W_MAX, W_MAX, W_MIN);
        extreme_points();
        random_points(120, NUM_RAND);
        drain();
        set_tool(W_MAX, 32'h7fff_ffff, W_MAX);
        extreme_points();
        random_points(100, NUM_RAND);
        drain();

        // Smallest legal tool.
        set_tool('0, 32'h0000_0001, '0);
        random_points(100, NUM_RAND);
        drain();

        // Random tools of ordinary size; the very last block runs with no idling.
        for (int ph = 0; ph < 4; ph++) begin
            set_tool($urandom_range(0, 32'h0040_0000) | ($urandom_range(0, 1) << 31),
                     $urandom_range(1, 32'h0010_0000),
                     $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
            random_points(140, (ph == 3) ? 140 - CALM_TAIL + 10 : NUM_RAND);
            if (ph != 3) drain();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 20) @(negedge i_clk);

        $display("Sent %0d points over 10 tool settings (reset, zero tube radius,", sent);
        $display("full-range radii and bottoms, random tools) under random stalls.");
        if (fail_count == 0) begin
            $display("torus_tool_point_distance verification clean");
        end else begin
            $display("torus_tool_point_distance verification failed");
        end
        $finish;
    end

endmodule

@@ torus_tool_point_distance.f @@
sv/ttpd_pkg.sv
sv/torus_tool_point_distance.sv
bench/ttpd_checker.sv
bench/tb_torus_tool_point_distance.sv
